@@ hdl/ctv_pkg.sv @@
// ----------------------------------------------------------------------------
// ctv_pkg
// Shared types and constants of the coverage / class-definition table
// validator: parse phases, error codes, register indexes, queue entry.
// ----------------------------------------------------------------------------
package ctv_pkg;

   localparam int WORD_W = 16;
   localparam int CODE_W = 4;
   localparam int CSR_INDEX_W = 2;

   // Front-to-back queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_GLYPH_TOTAL = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLASS_TOTAL = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TABLE_KIND  = 2'd2;

   // Format word values
   localparam logic [WORD_W-1:0] FORMAT_ONE = 16'd1;
   localparam logic [WORD_W-1:0] FORMAT_TWO = 16'd2;

   // Verdict codes
   localparam logic [CODE_W-1:0] ERR_NONE        = 4'd0;
   localparam logic [CODE_W-1:0] ERR_TRUNCATED   = 4'd1;
   localparam logic [CODE_W-1:0] ERR_BAD_FORMAT  = 4'd2;
   localparam logic [CODE_W-1:0] ERR_COUNT_BIG   = 4'd3;
   localparam logic [CODE_W-1:0] ERR_BAD_START   = 4'd4;
   localparam logic [CODE_W-1:0] ERR_BAD_GLYPH   = 4'd5;
   localparam logic [CODE_W-1:0] ERR_RANGE_ORDER = 4'd6;
   localparam logic [CODE_W-1:0] ERR_BAD_CLASS   = 4'd7;
   localparam logic [CODE_W-1:0] ERR_BAD_INDEX   = 4'd8;

   typedef enum logic [2:0] {
      PH_FORMAT,
      PH_START,
      PH_COUNT,
      PH_RECORD,
      PH_DONE
   } phase_type;

   // One classified word, as handed from the front to the back
   typedef struct packed {
      logic [WORD_W-1:0] word;
      logic              last;
      logic              class_kind;   // 1: class-definition table
      logic              above_glyph;  // word > glyph_total
      logic              class_bad;    // word == 0 or word > class_total
      logic              fmt_one;
      logic              fmt_two;
   } entry_type;

endpackage

@@ hdl/coverage_classdef_table_validator.sv @@
// ----------------------------------------------------------------------------
// coverage_classdef_table_validator
// Validates a font layout coverage or class-definition table streamed as
// 16-bit words and reports one verdict per table.
// ----------------------------------------------------------------------------
// Words are taken at one per cycle while the queue is not full. Each
// accepted word is classified against the configuration registers and placed
// in a four-entry queue; the checker behind the queue consumes one word per
// cycle, and a verdict is registered on rsp_ when the checker consumes the
// word that decides it, after any earlier words that wait ahead of it. A held
// verdict stalls only the checker; the queue keeps taking words until it
// fills. The table kind and bounds are read when a word is accepted, so
// write them between tables. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module coverage_classdef_table_validator (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [ctv_pkg::WORD_W-1:0]          req_word,
   input  logic                                req_last,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_table_ok,
   output logic [ctv_pkg::CODE_W-1:0]          rsp_error_code,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ctv_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [ctv_pkg::WORD_W-1:0]          csr_data
);

   logic [ctv_pkg::WORD_W-1:0] glyph_total_ff, glyph_total_in;
   logic [ctv_pkg::WORD_W-1:0] class_total_ff, class_total_in;
   logic                       table_kind_ff, table_kind_in;

   logic               queue_full;
   logic               push;
   ctv_pkg::entry_type push_entry;
   logic               pop;
   logic               head_valid;
   ctv_pkg::entry_type head_entry;

   assign csr_ready = 1'b1;

   always_comb begin
      glyph_total_in = glyph_total_ff;
      class_total_in = class_total_ff;
      table_kind_in  = table_kind_ff;
      if (csr_valid) begin
         case (csr_index)
            ctv_pkg::CSR_GLYPH_TOTAL: glyph_total_in = csr_data;
            ctv_pkg::CSR_CLASS_TOTAL: class_total_in = csr_data;
            ctv_pkg::CSR_TABLE_KIND:  table_kind_in  = csr_data[0];
            default: begin
               // Unmapped index: drop the write
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         glyph_total_ff <= '0;
         class_total_ff <= '0;
         table_kind_ff  <= 1'b0;
      end else begin
         glyph_total_ff <= glyph_total_in;
         class_total_ff <= class_total_in;
         table_kind_ff  <= table_kind_in;
      end
   end

   ctv_front u_front (
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_word    (req_word),
      .req_last    (req_last),
      .glyph_total (glyph_total_ff),
      .class_total (class_total_ff),
      .table_kind  (table_kind_ff),
      .queue_full  (queue_full),
      .push        (push),
      .push_entry  (push_entry)
   );

   ctv_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   ctv_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (head_valid),
      .head_entry     (head_entry),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_table_ok   (rsp_table_ok),
      .rsp_error_code (rsp_error_code)
   );

   // A passing verdict carries no error code, a failing one always does
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_table_ok == (rsp_error_code == ctv_pkg::ERR_NONE)))
      else $error("verdict flag and error code disagree");

   // The checker must not consume a word while its verdict is held
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> !pop)
      else $error("word consumed while output is blocked");

   // Error codes stay within the defined set
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_error_code <= ctv_pkg::ERR_BAD_INDEX))
      else $error("undefined error code");

   // Nothing is pushed into a full queue
   assert property (@(posedge clock) disable iff (reset)
      queue_full |-> !push)
      else $error("push into full queue");

endmodule

@@ hdl/ctv_front.sv @@
// ----------------------------------------------------------------------------
// ctv_front
// Accepts table words and classifies each against the configuration
// registers before it enters the queue.
// ----------------------------------------------------------------------------
module ctv_front (
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [ctv_pkg::WORD_W-1:0] req_word,
   input  logic                      req_last,
   input  logic [ctv_pkg::WORD_W-1:0] glyph_total,
   input  logic [ctv_pkg::WORD_W-1:0] class_total,
   input  logic                      table_kind,
   input  logic                      queue_full,
   output logic                      push,
   output ctv_pkg::entry_type        push_entry
);

   assign req_stall = queue_full;
   assign push      = req_valid & ~queue_full;

   always_comb begin
      push_entry             = '0;
      push_entry.word        = req_word;
      push_entry.last        = req_last;
      push_entry.class_kind  = table_kind;
      push_entry.above_glyph = req_word > glyph_total;
      push_entry.class_bad   = (req_word == '0) || (req_word > class_total);
      push_entry.fmt_one     = req_word == ctv_pkg::FORMAT_ONE;
      push_entry.fmt_two     = req_word == ctv_pkg::FORMAT_TWO;
   end

endmodule

@@ hdl/ctv_queue.sv @@
// ----------------------------------------------------------------------------
// ctv_queue
// Short first-in first-out queue of classified words between the front and
// the back.
// ----------------------------------------------------------------------------
module ctv_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  ctv_pkg::entry_type push_entry,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output ctv_pkg::entry_type head_entry
);

   ctv_pkg::entry_type                 slot_ff [ctv_pkg::QUEUE_DEPTH];
   logic [ctv_pkg::QUEUE_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [ctv_pkg::QUEUE_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [ctv_pkg::QUEUE_CNT_W-1:0]    count_ff, count_in;

   localparam logic [ctv_pkg::QUEUE_PTR_W-1:0] LAST_PTR =
      ctv_pkg::QUEUE_PTR_W'(ctv_pkg::QUEUE_DEPTH - 1);
   localparam logic [ctv_pkg::QUEUE_CNT_W-1:0] FULL_COUNT =
      ctv_pkg::QUEUE_CNT_W'(ctv_pkg::QUEUE_DEPTH);

   assign full       = count_ff == FULL_COUNT;
   assign head_valid = count_ff != '0;
   assign head_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

@@ hdl/ctv_back.sv @@
// ----------------------------------------------------------------------------
// ctv_back
// Walks the table structure one classified word per cycle while the output
// register is free, checks records and ranges, and holds the verdict there.
// ----------------------------------------------------------------------------
module ctv_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        head_valid,
   input  ctv_pkg::entry_type          head_entry,
   output logic                        pop,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_table_ok,
   output logic [ctv_pkg::CODE_W-1:0]  rsp_error_code
);

   ctv_pkg::phase_type                phase_ff, phase_in;
   logic                              format_two_ff, format_two_in;
   logic [ctv_pkg::WORD_W-1:0]        records_left_ff, records_left_in;
   logic [1:0]                        record_slot_ff, record_slot_in;
   logic [ctv_pkg::WORD_W-1:0]        range_first_ff, range_first_in;
   logic [ctv_pkg::WORD_W-1:0]        range_final_ff, range_final_in;
   logic [ctv_pkg::WORD_W-1:0]        previous_end_ff, previous_end_in;
   logic [ctv_pkg::WORD_W-1:0]        expected_ff, expected_in;

   logic                              out_valid_ff, out_valid_in;
   logic                              out_ok_ff, out_ok_in;
   logic [ctv_pkg::CODE_W-1:0]        out_code_ff, out_code_in;

   logic                              out_free;
   logic                              decided;
   logic [ctv_pkg::CODE_W-1:0]        code;
   logic                              record_done;
   logic [ctv_pkg::WORD_W-1:0]        records_dec;
   logic [ctv_pkg::WORD_W-1:0]        span;
   logic                              order_bad;

   // The output register takes a new verdict once the old one leaves
   assign out_free = ~out_valid_ff | ~rsp_stall;
   assign pop      = head_valid & out_free;

   assign rsp_valid      = out_valid_ff;
   assign rsp_table_ok   = out_ok_ff;
   assign rsp_error_code = out_code_ff;

   assign records_dec = records_left_ff - 16'd1;
   assign span        = range_final_ff - range_first_ff;
   assign order_bad   = (range_first_ff > range_final_ff) ||
                        ((previous_end_ff != '0) && (range_first_ff <= previous_end_ff));

   always_comb begin
      phase_in        = phase_ff;
      format_two_in   = format_two_ff;
      records_left_in = records_left_ff;
      record_slot_in  = record_slot_ff;
      range_first_in  = range_first_ff;
      range_final_in  = range_final_ff;
      previous_end_in = previous_end_ff;
      expected_in     = expected_ff;
      decided         = 1'b0;
      code            = ctv_pkg::ERR_NONE;
      record_done     = 1'b0;

      out_valid_in = out_valid_ff & rsp_stall;
      out_ok_in    = out_ok_ff;
      out_code_in  = out_code_ff;

      if (pop) begin
         case (phase_ff)
            ctv_pkg::PH_FORMAT: begin
               if (!head_entry.fmt_one && !head_entry.fmt_two) begin
                  decided = 1'b1;
                  code    = ctv_pkg::ERR_BAD_FORMAT;
               end else begin
                  format_two_in = head_entry.fmt_two;
                  phase_in = (head_entry.class_kind && !head_entry.fmt_two) ?
                             ctv_pkg::PH_START : ctv_pkg::PH_COUNT;
               end
            end
            ctv_pkg::PH_START: begin
               if (head_entry.above_glyph) begin
                  decided = 1'b1;
                  code    = ctv_pkg::ERR_BAD_START;
               end else begin
                  phase_in = ctv_pkg::PH_COUNT;
               end
            end
            ctv_pkg::PH_COUNT: begin
               if (head_entry.above_glyph) begin
                  decided = 1'b1;
                  code    = ctv_pkg::ERR_COUNT_BIG;
               end else begin
                  records_left_in = head_entry.word;
                  record_slot_in  = 2'd0;
                  if (head_entry.word == '0) begin
                     decided = 1'b1;
                  end else begin
                     phase_in = ctv_pkg::PH_RECORD;
                  end
               end
            end
            ctv_pkg::PH_RECORD: begin
               if (!format_two_ff) begin
                  if (!head_entry.class_kind && head_entry.above_glyph) begin
                     decided = 1'b1;
                     code    = ctv_pkg::ERR_BAD_GLYPH;
                  end else if (head_entry.class_kind && head_entry.class_bad) begin
                     decided = 1'b1;
                     code    = ctv_pkg::ERR_BAD_CLASS;
                  end else begin
                     record_done = 1'b1;
                  end
               end else if (record_slot_ff == 2'd0) begin
                  range_first_in = head_entry.word;
                  record_slot_in = 2'd1;
               end else if (record_slot_ff == 2'd1) begin
                  range_final_in = head_entry.word;
                  record_slot_in = 2'd2;
               end else begin
                  record_slot_in = 2'd0;
                  if (order_bad) begin
                     decided = 1'b1;
                     code    = ctv_pkg::ERR_RANGE_ORDER;
                  end else if (head_entry.class_kind && head_entry.class_bad) begin
                     decided = 1'b1;
                     code    = ctv_pkg::ERR_BAD_CLASS;
                  end else if (!head_entry.class_kind && (head_entry.word != expected_ff)) begin
                     decided = 1'b1;
                     code    = ctv_pkg::ERR_BAD_INDEX;
                  end else begin
                     if (!head_entry.class_kind) begin
                        expected_in = expected_ff + span + 16'd1;
                     end
                     previous_end_in = range_final_ff;
                     record_done     = 1'b1;
                  end
               end
               if (record_done) begin
                  records_left_in = records_dec;
                  if (records_dec == '0) begin
                     decided = 1'b1;
                  end
               end
            end
            default: begin
               // Verdict already out: drop words up to the marked last one
            end
         endcase

         if (phase_ff != ctv_pkg::PH_DONE) begin
            if (!decided && head_entry.last) begin
               decided = 1'b1;
               code    = ctv_pkg::ERR_TRUNCATED;
            end
            if (decided) begin
               out_valid_in = 1'b1;
               out_ok_in    = code == ctv_pkg::ERR_NONE;
               out_code_in  = code;
               phase_in     = ctv_pkg::PH_DONE;
            end
         end

         // End of table data: clear for the next table
         if (head_entry.last) begin
            phase_in        = ctv_pkg::PH_FORMAT;
            format_two_in   = 1'b0;
            records_left_in = '0;
            record_slot_in  = 2'd0;
            range_first_in  = '0;
            range_final_in  = '0;
            previous_end_in = '0;
            expected_in     = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= ctv_pkg::PH_FORMAT;
         format_two_ff   <= 1'b0;
         records_left_ff <= '0;
         record_slot_ff  <= 2'd0;
         range_first_ff  <= '0;
         range_final_ff  <= '0;
         previous_end_ff <= '0;
         expected_ff     <= '0;
         out_valid_ff    <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         format_two_ff   <= format_two_in;
         records_left_ff <= records_left_in;
         record_slot_ff  <= record_slot_in;
         range_first_ff  <= range_first_in;
         range_final_ff  <= range_final_in;
         previous_end_ff <= previous_end_in;
         expected_ff     <= expected_in;
         out_valid_ff    <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ok_ff   <= out_ok_in;
      out_code_ff <= out_code_in;
   end

endmodule
